### hdl/ssrch_pkg.sv
// shared types and constants for the streaming substring search
package ssrch_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int CHAR_BITS   = 8;
  localparam int INDEX_BITS  = 16;
  localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
  localparam int STATUS_BITS = 2;

  // opcodes
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_SATURATED = 2'd3;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]   LEN_MAX   = LEN_BITS'(MAX_PATTERN);

  typedef struct packed {
    logic                 opcode;
    logic [CHAR_BITS-1:0] char_value;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [INDEX_BITS-1:0]  match_position;
  } out_item_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic start;   // new pattern: drop stored pattern and match bits
    logic load;    // pattern item: write into first free cell
    logic search;  // text item: advance the match bits
    logic flush;   // end of text: clear match bits after this item
  } cell_ctrl_t;

endpackage

### hdl/substring_search_stream.sv
// Streaming first-occurrence substring search. Pattern items (opcode 0) fill a row of
// MAX_PATTERN cells, one character per cell, until an item with last set; text items
// (opcode 1) then stream past all cells at once, each cell keeping whether the pattern
// prefix ending at it matches at the current text position. The item with last set on
// the text yields one result: status and start index of the earliest match. One item
// is accepted every cycle; every cell compares in parallel and hands its match bit to
// its right neighbor, and the result sits in an output register, so the input stalls
// only while that register holds a result that the output side stalls.
module substring_search_stream (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  ssrch_pkg::in_item_t  in_item_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output ssrch_pkg::out_item_t out_item_o,
  input  logic                 out_stall_i
);
  import ssrch_pkg::*;

  logic                  in_acc;
  logic                  is_text;
  logic                  searching;
  logic                  text_end;
  cell_ctrl_t            ctrl;

  logic                  start_new_q, start_new_d;
  logic [LEN_BITS-1:0]   len_q, len_d, len_base;
  logic                  ovf_q, ovf_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d, idx_next;
  logic                  found_q, found_d, found_now;
  logic [INDEX_BITS-1:0] pos_q, pos_d, pos_now;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  logic [MAX_PATTERN-1:0] active;
  logic [MAX_PATTERN-1:0] match;
  logic [MAX_PATTERN-1:0] match_next;
  logic [MAX_PATTERN-1:0] tail;
  logic                   full_hit;

  // handshake
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign is_text   = (in_item_i.opcode == OP_TEXT);
  assign searching = in_acc & is_text & (idx_q != INDEX_MAX);
  assign text_end  = in_acc & is_text & in_item_i.last;

  always_comb begin
    ctrl.load   = in_acc & ~is_text;
    ctrl.start  = ctrl.load & start_new_q;
    ctrl.search = searching;
    ctrl.flush  = text_end;
  end

  // chain of cells
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev_active;
    logic prev_match;
    if (k == 0) begin : g_head
      assign prev_active = 1'b1;
      assign prev_match  = 1'b1;
    end else begin : g_body
      assign prev_active = active[k-1];
      assign prev_match  = match[k-1];
    end
    ssrch_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .char_i       (in_item_i.char_value),
      .prev_active_i(prev_active),
      .prev_match_i (prev_match),
      .active_o     (active[k]),
      .match_o      (match[k]),
      .match_next_o (match_next[k])
    );
    // last filled cell of the pattern
    if (k == MAX_PATTERN - 1) begin : g_tail_end
      assign tail[k] = active[k];
    end else begin : g_tail_mid
      assign tail[k] = active[k] & ~active[k+1];
    end
  end

  assign full_hit = |(match_next & tail);

  // pattern length and overflow
  always_comb begin
    len_base    = ctrl.start ? '0 : len_q;
    len_d       = len_q;
    ovf_d       = ctrl.start ? 1'b0 : ovf_q;
    start_new_d = start_new_q;
    if (ctrl.load) begin
      if (len_base < LEN_MAX) begin
        len_d = len_base + LEN_BITS'(1);
      end else begin
        len_d = len_base;
        ovf_d = 1'b1;
      end
      start_new_d = in_item_i.last;
    end
    if (in_acc && is_text) begin
      start_new_d = 1'b1;
    end
  end

  // text index and earliest match
  always_comb begin
    idx_next  = (idx_q != INDEX_MAX) ? idx_q + INDEX_BITS'(1) : idx_q;
    found_now = found_q;
    pos_now   = pos_q;
    if (searching && !found_q && full_hit) begin
      found_now = 1'b1;
      pos_now   = idx_q - INDEX_BITS'(len_q) + INDEX_BITS'(1);
    end
    idx_d   = idx_q;
    found_d = found_q;
    pos_d   = pos_q;
    if (ctrl.start || text_end) begin
      idx_d   = '0;
      found_d = 1'b0;
      pos_d   = '0;
    end else if (in_acc && is_text) begin
      idx_d   = idx_next;
      found_d = found_now;
      pos_d   = pos_now;
    end
  end

  // result of the item that ends the text
  always_comb begin
    out_d.match_position = '0;
    if (len_q == '0) begin
      out_d.status = ST_NOT_FOUND;
    end else if (ovf_q) begin
      out_d.status = ST_TOO_LONG;
    end else if (found_now) begin
      out_d.status         = ST_FOUND;
      out_d.match_position = pos_now;
    end else if (idx_next == INDEX_MAX) begin
      out_d.status = ST_SATURATED;
    end else begin
      out_d.status = ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_new_q <= 1'b1;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_new_q <= start_new_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      pos_q       <= pos_d;
      if (text_end) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (text_end) begin
      out_q <= out_d;
    end
  end

endmodule

### hdl/ssrch_cell.sv
// one cell of the chain: a pattern character, its fill flag and its match bit
module ssrch_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssrch_pkg::cell_ctrl_t          ctrl_i,
  input  logic [ssrch_pkg::CHAR_BITS-1:0] char_i,
  input  logic                           prev_active_i,
  input  logic                           prev_match_i,
  output logic                           active_o,
  output logic                           match_o,
  output logic                           match_next_o
);
  import ssrch_pkg::*;

  logic [CHAR_BITS-1:0] char_q;
  logic                 active_q, active_d;
  logic                 match_q, match_d;
  logic                 wr;
  logic                 hit;

  // fill flag as seen after a new-pattern clear
  assign active_o = active_q & ~ctrl_i.start;
  assign match_o  = match_q;

  // this cell takes the character when it is the first free one
  assign wr       = ctrl_i.load & prev_active_i & ~active_o;
  assign active_d = active_o | wr;

  // prefix ending here extends the prefix held by the left neighbor
  assign hit          = prev_match_i & active_q & (char_q == char_i);
  assign match_next_o = hit;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.search) begin
      match_d = hit;
    end
    if (ctrl_i.start || ctrl_i.flush) begin
      match_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      match_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      match_q  <= match_d;
    end
  end

  // stored character
  always_ff @(posedge clk_i) begin
    if (wr) begin
      char_q <= char_i;
    end
  end

endmodule
